[hw/rtl/dfq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfq_pkg
// Shared constants and types for the deduplicating key queue.
// ----------------------------------------------------------------------------
package dfq_pkg;

    localparam int DEPTH     = 16;
    localparam int KEY_WIDTH = 32;
    localparam int CNT_WIDTH = $clog2(DEPTH + 1);

    // transaction status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // operation codes
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // per-cell control from the queue controller
    typedef struct packed {
        logic occupied;
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage : dfq_pkg
`default_nettype wire

[hw/rtl/dfq_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfq_cell
// One queue slot: holds a key, matches it against the incoming key and takes
// its neighbor's key when the queue advances.
// ----------------------------------------------------------------------------
module dfq_cell
    import dfq_pkg::*;
(
    input  wire logic                 clk,
    input  wire cell_ctrl_t           ctrl,
    input  wire logic [KEY_WIDTH-1:0] key_in,
    input  wire logic [KEY_WIDTH-1:0] neighbor_key,
    output logic      [KEY_WIDTH-1:0] key,
    output logic                      match
);

    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;

    // next key: shift from neighbor on pop, capture on push
    always_comb
    begin
        key_next = key_reg;
        if (ctrl.shift)
        begin
            key_next = neighbor_key;
        end
        else if (ctrl.load)
        begin
            key_next = key_in;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    // match line only from occupied slots
    assign match = ctrl.occupied && (key_reg == key_in);
    assign key   = key_reg;

endmodule : dfq_cell
`default_nettype wire

[hw/rtl/dedup_fifo_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dedup_fifo_queue
// First-in first-out queue of keys that drops pushes of keys already held.
// ----------------------------------------------------------------------------
// The queue takes one push or pop transaction per clock and returns its result
// in the next cycle; it sustains one transaction per cycle as long as results are
// taken. Every slot compares its key against the incoming key in the same
// cycle and the match lines are ORed, so this compare and the slot chain's
// shift on pop set the cycle time. The oldest key sits in slot 0; a pop moves
// every slot one step toward it. A push of a key already held reports a
// duplicate even when the queue is full. No clearing pass after reset.
// ----------------------------------------------------------------------------
module dedup_fifo_queue
    import dfq_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 action,
    input  wire logic [KEY_WIDTH-1:0] key_in,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic      [KEY_WIDTH-1:0] key_out,
    output logic      [1:0]           status,
    output logic      [CNT_WIDTH-1:0] occupancy
);

    logic [CNT_WIDTH-1:0] count_reg;
    logic [CNT_WIDTH-1:0] count_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [KEY_WIDTH-1:0] key_out_reg;
    logic [KEY_WIDTH-1:0] key_out_next;
    logic [1:0]           status_reg;
    logic [1:0]           status_next;

    logic                 accept;
    logic                 dup;
    logic                 do_load;
    logic                 do_shift;
    logic [DEPTH-1:0]     match;
    logic [KEY_WIDTH-1:0] cell_key [DEPTH];

    // input taken whenever the result register is free or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign dup      = |match;

    // slot chain
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [CNT_WIDTH-1:0] IDX = CNT_WIDTH'(i);
        cell_ctrl_t           ctrl;
        logic [KEY_WIDTH-1:0] neighbor_key;

        assign ctrl = '{occupied: (IDX < count_reg),
                        load:     (do_load && (count_reg == IDX)),
                        shift:    do_shift};

        if (i == DEPTH - 1)
        begin : g_last
            assign neighbor_key = '0;
        end
        else
        begin : g_mid
            assign neighbor_key = cell_key[i+1];
        end

        dfq_cell u_cell (
            .clk          (clk),
            .ctrl         (ctrl),
            .key_in       (key_in),
            .neighbor_key (neighbor_key),
            .key          (cell_key[i]),
            .match        (match[i])
        );
    end

    // transaction decode
    always_comb
    begin
        count_next     = count_reg;
        key_out_next   = key_out_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !out_ready;
        do_load        = 1'b0;
        do_shift       = 1'b0;
        if (accept)
        begin
            out_valid_next = 1'b1;
            key_out_next   = '0;
            status_next    = ST_DONE;
            if (action == ACT_PUSH)
            begin
                priority if (dup)
                begin
                    status_next = ST_DUP;
                end
                else if (count_reg == CNT_WIDTH'(DEPTH))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    do_load    = 1'b1;
                    count_next = count_reg + CNT_WIDTH'(1);
                end
            end
            else
            begin
                if (count_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    do_shift     = 1'b1;
                    key_out_next = cell_key[0];
                    count_next   = count_reg - CNT_WIDTH'(1);
                end
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload registers
    always_ff @(posedge clk)
    begin
        key_out_reg <= key_out_next;
        status_reg  <= status_next;
    end

    // occupancy follows the last accepted transaction
    logic [CNT_WIDTH-1:0] occupancy_reg;
    logic [CNT_WIDTH-1:0] occupancy_next;

    assign occupancy_next = accept ? count_next : occupancy_reg;

    always_ff @(posedge clk)
    begin
        occupancy_reg <= occupancy_next;
    end

    assign out_valid = out_valid_reg;
    assign key_out   = key_out_reg;
    assign status    = status_reg;
    assign occupancy = occupancy_reg;

endmodule : dedup_fifo_queue
`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the deduplicating key queue. A directed table covers
// the empty, full and duplicate corners, then random push/pop traffic with
// duplicate-heavy keys runs under changing backpressure. Each result is checked
// against the row's expectation or a behavioral queue model kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
    import dfq_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 342;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] key;
        logic [1:0]           status;
        logic [CNT_WIDTH-1:0] occ;
    } queue_result_t;

    typedef struct {
        logic          act;
        logic [31:0]   key;
        bit            typed;
        queue_result_t expect_res;
    } stim_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic                 action    = ACT_PUSH;
    logic [KEY_WIDTH-1:0] key_in    = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [KEY_WIDTH-1:0] key_out;
    logic [1:0]           status;
    logic [CNT_WIDTH-1:0] occupancy;

    // bench-side copy of the typed expectation riding with each transaction
    bit                   row_typed  = 1'b0;
    queue_result_t        row_expect = '0;

    logic [KEY_WIDTH-1:0] held_keys[$];
    queue_result_t        expected_results[$];
    stim_row_t            directed_rows[$];
    int                   error_count   = 0;
    int                   stall_cycles  = 0;
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;

    dedup_fifo_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .key_in    (key_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .key_out   (key_out),
        .status    (status),
        .occupancy (occupancy)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // queue behavior: one push or pop against the held keys
    function automatic queue_result_t apply_queue_op(input logic act,
                                                     input logic [KEY_WIDTH-1:0] key);
        queue_result_t res;
        bit            found;
        res.key    = '0;
        res.status = ST_DONE;
        found      = 1'b0;
        if (act == ACT_PUSH)
        begin
            foreach (held_keys[i])
                if (held_keys[i] == key)
                    found = 1'b1;
            // duplicate check wins over full
            if (found)
                res.status = ST_DUP;
            else if (held_keys.size() >= DEPTH)
                res.status = ST_FULL;
            else
                held_keys = {held_keys, key};
        end
        else
        begin
            if (held_keys.size() == 0)
                res.status = ST_EMPTY;
            else
            begin
                res.key = held_keys[0];
                held_keys.delete(0);
            end
        end
        res.occ = CNT_WIDTH'(held_keys.size());
        return res;
    endfunction

    // receiver backpressure
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // accepted transactions: predict, check and watch for a hang
    always @(posedge clk)
    begin : monitor
        queue_result_t predicted;
        queue_result_t want;
        bit            moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (in_valid && in_ready)
            begin
                moved     = 1'b1;
                predicted = apply_queue_op(action, key_in);
                expected_results = {expected_results,
                                    (row_typed ? row_expect : predicted)};
            end
            if (out_valid && out_ready)
            begin
                moved = 1'b1;
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result key_out=%h status=%0d occupancy=%0d",
                             $time, key_out, status, occupancy);
                end
                else
                begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (key_out !== want.key)
                    begin
                        error_count++;
                        $display("%0t: key_out expected %h actual %h",
                                 $time, want.key, key_out);
                    end
                    if (status !== want.status)
                    begin
                        error_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, status);
                    end
                    if (occupancy !== want.occ)
                    begin
                        error_count++;
                        $display("%0t: occupancy expected %0d actual %0d",
                                 $time, want.occ, occupancy);
                    end
                end
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // one push or pop, held until accepted
    task automatic send_item(input logic act, input logic [KEY_WIDTH-1:0] key,
                             input bit typed, input queue_result_t exp_res);
        in_valid   <= 1'b1;
        action     <= act;
        key_in     <= key;
        row_typed  <= typed;
        row_expect <= exp_res;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // random sender gaps ahead of a transaction
    task automatic sender_gap();
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // hold off new transactions until every result is back
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_row(input logic act, input logic [31:0] key, input bit typed,
                           input logic [31:0] ekey, input logic [1:0] est,
                           input int eocc);
        stim_row_t row;
        row.act               = act;
        row.key               = key;
        row.typed             = typed;
        row.expect_res.key    = ekey;
        row.expect_res.status = est;
        row.expect_res.occ    = CNT_WIDTH'(eocc);
        directed_rows = {directed_rows, row};
    endtask

    // random traffic: randomly switched fill and drain bias, keys favor duplicates
    task automatic run_random_phase(input int n_items);
        int                   push_pct;
        int                   pick;
        logic                 act;
        logic [KEY_WIDTH-1:0] key;
        push_pct = 70;
        for (int k = 0; k < n_items; k++)
        begin
            if (k % 48 == 0)
                push_pct = $urandom_range(0, 1) ? 78 : 30;
            if (k == n_items / 2)
                wait_results_drained();
            sender_gap();
            act  = ($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_POP;
            pick = $urandom_range(0, 9);
            if (pick < 3 && held_keys.size() != 0)
                key = held_keys[$urandom_range(0, held_keys.size() - 1)];
            else if (pick < 6)
                key = KEY_WIDTH'($urandom_range(0, 23));
            else
                key = $urandom();
            send_item(act, key, 1'b0, '0);
        end
    endtask

    initial
    begin
        // empty queue, both key extremes, duplicate and pop order
        add_row(ACT_POP,  32'h1234_5678, 1'b1, 32'h0000_0000, ST_EMPTY, 0);
        add_row(ACT_PUSH, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_DONE,  1);
        add_row(ACT_PUSH, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_DUP,   1);
        add_row(ACT_PUSH, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_DONE,  2);
        add_row(ACT_POP,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_DONE,  1);
        add_row(ACT_POP,  32'h0000_0000, 1'b1, 32'hFFFF_FFFF, ST_DONE,  0);
        add_row(ACT_POP,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_EMPTY, 0);
        // fill to capacity
        for (int i = 0; i < DEPTH; i++)
            add_row(ACT_PUSH, 32'h1 << (2 * i), 1'b0, '0, ST_DONE, 0);
        // push new key when full, then duplicate while full
        add_row(ACT_PUSH, 32'hDEAD_BEEF, 1'b1, 32'h0000_0000, ST_FULL, DEPTH);
        add_row(ACT_PUSH, 32'h0000_0010, 1'b1, 32'h0000_0000, ST_DUP,  DEPTH);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 13;
        recv_idle_pct = 72;
        foreach (directed_rows[i])
        begin
            sender_gap();
            send_item(directed_rows[i].act, directed_rows[i].key,
                      directed_rows[i].typed, directed_rows[i].expect_res);
        end
        run_random_phase(PHASE_ITEMS);

        send_idle_pct = 72;
        recv_idle_pct = 13;
        run_random_phase(PHASE_ITEMS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(PHASE_ITEMS);

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule : testbench

[dedup_fifo_queue.f]
hw/rtl/dfq_pkg.sv
hw/rtl/dfq_cell.sv
hw/rtl/dedup_fifo_queue.sv
bench/testbench.sv
